// File: hdl/wcd_pkg.sv
// wcd_pkg: shared types, register indexes and reset constants for the
// window count debouncer. No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package wcd_pkg;

    localparam int WINDOW_DEFAULT = 10;

    localparam int TIME_W = 32;
    localparam int THR_W  = 4;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [IDX_W-1:0] REG_RISE_THRESHOLD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FALL_THRESHOLD  = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd10;
    localparam logic [THR_W-1:0]  RISE_RESET     = 4'd5;
    localparam logic [THR_W-1:0]  FALL_RESET     = 4'd3;

    typedef struct packed {
        logic [TIME_W-1:0] sample_interval;
        logic [THR_W-1:0]  rise_threshold;
        logic [THR_W-1:0]  fall_threshold;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              pin_level;
        logic              query_trigger;
    } t_item;

    typedef struct packed {
        logic sampled;
        logic level;
        logic triggered;
    } t_result;

endpackage

// File: hdl/wcd_cfg_regs.sv
// wcd_cfg_regs: configuration register file (interval and thresholds).
// Depends on wcd_pkg.
`timescale 1ns / 1ps

module wcd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wcd_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [wcd_pkg::CFG_W-1:0]   i_cfg_data,
    output wcd_pkg::t_cfg               o_cfg
);

    wcd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval <= wcd_pkg::INTERVAL_RESET;
            r_cfg.rise_threshold  <= wcd_pkg::RISE_RESET;
            r_cfg.fall_threshold  <= wcd_pkg::FALL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wcd_pkg::REG_SAMPLE_INTERVAL: begin
                    r_cfg.sample_interval <= i_cfg_data[wcd_pkg::TIME_W-1:0];
                end
                wcd_pkg::REG_RISE_THRESHOLD: begin
                    r_cfg.rise_threshold <= i_cfg_data[wcd_pkg::THR_W-1:0];
                end
                wcd_pkg::REG_FALL_THRESHOLD: begin
                    r_cfg.fall_threshold <= i_cfg_data[wcd_pkg::THR_W-1:0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/wcd_core.sv
// wcd_core: debounce state (sample window, ones count, level, armed flag,
// next sample time) and its update on each advance. Depends on wcd_pkg.
`timescale 1ns / 1ps

module wcd_core #(
    parameter int WINDOW = wcd_pkg::WINDOW_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  wcd_pkg::t_item   i_item,
    input  wcd_pkg::t_cfg    i_cfg,
    output wcd_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int CMP_W = (CNT_W > wcd_pkg::THR_W) ? CNT_W : wcd_pkg::THR_W;

    logic [WINDOW-1:0]              r_window, n_window;
    logic [CNT_W-1:0]               r_count,  n_count;
    logic                           r_level,  n_level;
    logic                           r_armed,  n_armed;
    logic [wcd_pkg::TIME_W-1:0]     r_next_time, n_next_time;

    logic                           do_sample;
    logic                           fired;
    logic [CMP_W-1:0]               cnt_ext, rise_ext, fall_ext;

    always_comb begin
        do_sample   = i_item.time_now > r_next_time;
        n_window    = r_window;
        n_count     = r_count;
        n_level     = r_level;
        n_next_time = r_next_time;
        n_armed     = r_armed;
        fired       = 1'b0;

        if (do_sample) begin
            n_count = r_count - CNT_W'(r_window[WINDOW-1])
                              + CNT_W'(i_item.pin_level);
            n_window    = {r_window[WINDOW-2:0], i_item.pin_level};
            n_next_time = i_item.time_now + i_cfg.sample_interval;
        end

        cnt_ext  = CMP_W'(n_count);
        rise_ext = CMP_W'(i_cfg.rise_threshold);
        fall_ext = CMP_W'(i_cfg.fall_threshold);

        if (do_sample) begin
            if (r_level) begin
                if (cnt_ext < fall_ext) begin
                    n_level = 1'b0;
                end
            end else begin
                if (cnt_ext > rise_ext) begin
                    n_level = 1'b1;
                end
            end
        end

        if (i_item.query_trigger) begin
            if (n_level) begin
                if (r_armed) begin
                    n_armed = 1'b0;
                    fired   = 1'b1;
                end
            end else begin
                n_armed = 1'b1;
            end
        end

        o_result.sampled   = do_sample;
        o_result.level     = n_level;
        o_result.triggered = fired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_count     <= '0;
            r_level     <= 1'b0;
            r_armed     <= 1'b1;
            r_next_time <= '0;
        end else if (i_advance) begin
            r_window    <= n_window;
            r_count     <= n_count;
            r_level     <= n_level;
            r_armed     <= n_armed;
            r_next_time <= n_next_time;
        end
    end

endmodule

// File: hdl/window_count_debouncer.sv
// window_count_debouncer: top level with input and result registers around
// the debounce core. Depends on wcd_pkg, wcd_cfg_regs and wcd_core.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_time_now, i_pin_level, i_query_trigger
// result    out        o_out_valid / i_out_stall o_sampled, o_level, o_triggered
// config    in         i_cfg_we (no handshake)   i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result channel is not stalled;
// each item is registered in the input register and then in the result
// register, which loads as the item leaves the input register.
// The state update (window shift, count, hysteresis, armed flag, next sample
// time) happens in the cycle an item moves from the input register to the
// result register, so back-to-back items each see the previous item's state.
// Reset is synchronous, active low: window and count zero, level low, armed
// set, next sample time zero, config registers at their defaults.
// A stalled result holds; the input register keeps taking a transfer as long
// as either register has room.

module window_count_debouncer #(
    parameter int WINDOW = wcd_pkg::WINDOW_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wcd_pkg::TIME_W-1:0]  i_time_now,
    input  logic                        i_pin_level,
    input  logic                        i_query_trigger,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_sampled,
    output logic                        o_level,
    output logic                        o_triggered,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [wcd_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [wcd_pkg::CFG_W-1:0]   i_cfg_data
);

    wcd_pkg::t_cfg    cfg;
    wcd_pkg::t_item   r_item;
    wcd_pkg::t_result core_result;
    wcd_pkg::t_result r_result;
    logic             r_in_valid;
    logic             r_out_valid;

    logic             out_free;   // result register can take a new result
    logic             advance;    // move item from input to result register
    logic             in_take;    // input transfer this cycle

    wcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wcd_core #(
        .WINDOW (WINDOW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // Result register drains when the consumer takes it; the input register
    // frees up whenever its item advances.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register: payload, loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.time_now      <= i_time_now;
            r_item.pin_level     <= i_pin_level;
            r_item.query_trigger <= i_query_trigger;
        end
    end

    // Result register: control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sampled   = r_result.sampled;
    assign o_level     = r_result.level;
    assign o_triggered = r_result.triggered;

    // A trigger only fires while the debounced level is high.
    a_trig_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_triggered || o_level))
        else $error("trigger reported with low level");

    // An item that advances always shows up as a result next cycle.
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item missing on output");

    // Back-pressure only when both registers are full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room available");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for window_count_debouncer. Predicts every result
// in-line from its own copy of the debounce state. Depends on wcd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int WINDOW       = wcd_pkg::WINDOW_DEFAULT;
    localparam int TIME_W       = wcd_pkg::TIME_W;
    localparam int THR_W        = wcd_pkg::THR_W;
    localparam int CFG_W        = wcd_pkg::CFG_W;
    localparam int IDX_W        = wcd_pkg::IDX_W;
    localparam int LONG_HOLD    = 150;      // receiver back-pressure stretch
    localparam int DRAIN_CYCLES = 6;        // idle clocks after the queues empty
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    // Index 3 decodes to no register; writes there must be ignored.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // DUT ports; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic              in_valid   = 1'b0;
    logic              o_in_stall;
    wcd_pkg::t_item    cur_item   = '0;
    logic              o_out_valid;
    logic              out_stall  = 1'b0;
    logic              o_sampled;
    logic              o_level;
    logic              o_triggered;
    logic              cfg_we     = 1'b0;
    logic [IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]  cfg_data   = '0;

    window_count_debouncer #(
        .WINDOW (WINDOW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_time_now      (cur_item.time_now),
        .i_pin_level     (cur_item.pin_level),
        .i_query_trigger (cur_item.query_trigger),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_sampled       (o_sampled),
        .o_level         (o_level),
        .o_triggered     (o_triggered),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: registers and debounce state after reset
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] m_interval  = wcd_pkg::INTERVAL_RESET;
    logic [THR_W-1:0]  m_rise      = wcd_pkg::RISE_RESET;
    logic [THR_W-1:0]  m_fall      = wcd_pkg::FALL_RESET;
    logic [WINDOW-1:0] m_window    = '0;
    int                m_ones      = 0;
    logic              m_level     = 1'b0;
    logic              m_armed     = 1'b1;
    logic [TIME_W-1:0] m_next_time = '0;

    wcd_pkg::t_item   stamp_q[$];              // time stamps waiting to be driven
    wcd_pkg::t_result debounce_results_q[$];   // predicted results, oldest first

    int mismatches = 0;
    int cycles     = 0;
    int hold_asked = 0;               // bumped by the sequencer to request a long hold

    // Advance the predicted debouncer by one accepted transfer.
    function automatic wcd_pkg::t_result debounce_predict(wcd_pkg::t_item it);
        wcd_pkg::t_result r;
        r = '0;
        // Sample only when the stamp is strictly past the scheduled time;
        // plain unsigned compare, no wrap handling.
        if (it.time_now > m_next_time) begin
            if (m_window[WINDOW-1])
                m_ones--;
            if (it.pin_level)
                m_ones++;
            m_window = {m_window[WINDOW-2:0], it.pin_level};
            // Hysteresis: only the threshold for the opposite level applies.
            if (m_level) begin
                if (m_ones < int'(m_fall))
                    m_level = 1'b0;
            end else if (m_ones > int'(m_rise)) begin
                m_level = 1'b1;
            end
            m_next_time = it.time_now + m_interval;
            r.sampled   = 1'b1;
        end
        // One-shot: fire once per high period; a query at low level re-arms.
        if (it.query_trigger) begin
            if (m_level) begin
                if (m_armed) begin
                    m_armed     = 1'b0;
                    r.triggered = 1'b1;
                end
            end else begin
                m_armed = 1'b1;
            end
        end
        r.level = m_level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: feed stamp_q, random gap per item, occasional bursts
    // ------------------------------------------------------------------
    int tx_gap   = 0;
    int tx_burst = 0;

    always @(posedge i_clk) begin : stamp_driver
        logic took;
        took = in_valid && !o_in_stall;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
            tx_burst <= 0;
        end else begin
            if (took)
                debounce_results_q.push_back(debounce_predict(cur_item));
            // Load a new item only once the current one has transferred.
            if (!in_valid || took) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (stamp_q.size() > 0) begin
                    cur_item <= stamp_q.pop_front();
                    in_valid <= 1'b1;
                    // Draw the wait before the following item.
                    if (tx_burst > 0) begin
                        tx_burst <= tx_burst - 1;
                        tx_gap   <= 0;
                    end else if ($urandom_range(0, 39) == 0) begin
                        tx_burst <= 30;
                        tx_gap   <= 0;
                    end else begin
                        tx_gap <= $urandom_range(0, 11);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each transfer, drive random stall
    // ------------------------------------------------------------------
    int rx_wait   = 0;
    int rx_burst  = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin : result_monitor
        wcd_pkg::t_result got;
        wcd_pkg::t_result want;
        int               w;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
            rx_burst  <= 0;
            hold_left <= 0;
        end else begin
            w = rx_wait;
            if (o_out_valid && !out_stall) begin
                got = '{sampled: o_sampled, level: o_level, triggered: o_triggered};
                if (debounce_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: sampled=%0b level=%0b triggered=%0b",
                                 got.sampled, got.level, got.triggered);
                end else begin
                    want = debounce_results_q.pop_front();
                    if (got.sampled !== want.sampled || got.level !== want.level ||
                        got.triggered !== want.triggered) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch: expected sampled=%0b level=%0b ",
                                      "triggered=%0b, got sampled=%0b level=%0b triggered=%0b"},
                                     want.sampled, want.level, want.triggered,
                                     got.sampled, got.level, got.triggered);
                    end
                end
                // Draw the stall before taking the next result.
                if (rx_burst > 0) begin
                    rx_burst <= rx_burst - 1;
                    w = 0;
                end else if ($urandom_range(0, 39) == 0) begin
                    rx_burst <= 30;
                    w = 0;
                end else begin
                    w = $urandom_range(0, 11);
                end
            end
            // A requested long hold takes priority over the per-item stall.
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
                rx_wait   <= w;
            end else if (hold_seen != hold_asked) begin
                hold_seen <= hold_asked;
                hold_left <= LONG_HOLD - 1;
                out_stall <= 1'b1;
                rx_wait   <= w;
            end else if (w > 0) begin
                out_stall <= 1'b1;
                rx_wait   <= w - 1;
            end else begin
                out_stall <= 1'b0;
                rx_wait   <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // Write one register and mirror it into the predictor.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            wcd_pkg::REG_SAMPLE_INTERVAL: m_interval = data;
            wcd_pkg::REG_RISE_THRESHOLD:  m_rise     = data[THR_W-1:0];
            wcd_pkg::REG_FALL_THRESHOLD:  m_fall     = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Threshold write with junk in the unused upper bits.
    function automatic logic [CFG_W-1:0] thr_word(input logic [THR_W-1:0] thr);
        return {$urandom} & ~CFG_W'(4'hF) | CFG_W'(thr);
    endfunction

    // Hold until every queued item has transferred and every result is back.
    // Check between edges so the driver's updates of the same edge have settled.
    task automatic wait_drained();
        while (stamp_q.size() != 0 || in_valid || debounce_results_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_stamp(input logic [TIME_W-1:0] t, input logic pin,
                                        input logic query);
        wcd_pkg::t_item it;
        it.time_now      = t;
        it.pin_level     = pin;
        it.query_trigger = query;
        stamp_q.push_back(it);
    endfunction

    // Mostly forward-moving time with a bouncy pin; a few jumps to random
    // stamps and small steps back.
    function automatic void queue_random_stamps(input int count, input logic [TIME_W-1:0] start);
        logic [TIME_W-1:0] run_t;
        logic              true_pin;
        int                span;
        run_t    = start;
        true_pin = 1'b0;
        span     = (m_interval > 32'd1000) ? 40 : int'(m_interval) * 2 + 3;
        repeat (count) begin
            if ($urandom_range(0, 99) < 5)
                run_t = $urandom;
            else if ($urandom_range(0, 99) < 3)
                run_t = run_t - $urandom_range(0, 50);
            else
                run_t = run_t + $urandom_range(0, span);
            if ($urandom_range(0, 11) == 0)
                true_pin = ~true_pin;
            queue_stamp(run_t, true_pin ^ ($urandom_range(0, 9) == 0),
                        $urandom_range(0, 2) == 0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings (interval 10, rise above 5, fall below 3).
        queue_stamp(32'd0, 1'b1, 1'b1);     // equal to next time: no sample, query at low
        queue_stamp(32'd1, 1'b1, 1'b0);     // first sample
        queue_stamp(32'd11, 1'b1, 1'b1);    // exactly at next time: no sample
        queue_stamp(32'd12, 1'b1, 1'b0);
        queue_stamp(32'd23, 1'b1, 1'b0);
        queue_stamp(32'd34, 1'b1, 1'b0);
        queue_stamp(32'd45, 1'b1, 1'b1);    // five ones: still low
        queue_stamp(32'd56, 1'b1, 1'b1);    // six ones: rises, fires
        queue_stamp(32'd57, 1'b1, 1'b1);    // disarmed: no second shot
        queue_stamp(32'd67, 1'b0, 1'b0);    // no query leaves armed alone
        queue_stamp(32'd78, 1'b0, 1'b1);
        queue_stamp(32'd89, 1'b0, 1'b0);
        queue_stamp(32'd100, 1'b0, 1'b0);
        queue_stamp(32'd111, 1'b0, 1'b0);   // oldest ones start leaving the window
        queue_stamp(32'd122, 1'b0, 1'b0);
        queue_stamp(32'd133, 1'b0, 1'b0);
        queue_stamp(32'd144, 1'b0, 1'b1);   // count drops below fall: low, re-arm
        queue_stamp(32'hFFFF_FFFF, 1'b1, 1'b1); // next time wraps to 9
        queue_stamp(32'd5, 1'b1, 1'b0);     // below wrapped next time
        queue_stamp(32'd10, 1'b1, 1'b1);
        wait_drained();

        queue_random_stamps(240, 32'h100);
        wait_drained();

        // Zero interval and zero thresholds.
        write_reg(wcd_pkg::REG_SAMPLE_INTERVAL, 32'd0);
        write_reg(wcd_pkg::REG_RISE_THRESHOLD, thr_word(4'd0));
        write_reg(wcd_pkg::REG_FALL_THRESHOLD, thr_word(4'd0));
        queue_random_stamps(200, $urandom);
        wait_drained();

        // Largest interval and thresholds; next time lands one below the stamp.
        write_reg(wcd_pkg::REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
        write_reg(wcd_pkg::REG_RISE_THRESHOLD, thr_word(4'd15));
        write_reg(wcd_pkg::REG_FALL_THRESHOLD, thr_word(4'd15));
        write_reg(REG_SPARE, $urandom);
        queue_random_stamps(200, 32'hFFFF_FF00);
        wait_drained();

        // Fall above rise, with a long receiver hold while items keep coming.
        write_reg(wcd_pkg::REG_SAMPLE_INTERVAL, 32'd3);
        write_reg(wcd_pkg::REG_RISE_THRESHOLD, thr_word(4'd2));
        write_reg(wcd_pkg::REG_FALL_THRESHOLD, thr_word(4'd8));
        queue_random_stamps(250, $urandom_range(0, 1000));
        hold_asked++;
        wait_drained();

        // Near the window size.
        write_reg(wcd_pkg::REG_SAMPLE_INTERVAL, $urandom_range(1, 40));
        write_reg(wcd_pkg::REG_RISE_THRESHOLD, thr_word(4'd9));
        write_reg(wcd_pkg::REG_FALL_THRESHOLD, thr_word(4'd10));
        queue_random_stamps(200, $urandom);
        wait_drained();

        // Ordinary settings, second long hold part way through.
        write_reg(wcd_pkg::REG_SAMPLE_INTERVAL, $urandom_range(5, 60));
        write_reg(wcd_pkg::REG_RISE_THRESHOLD, thr_word(4'd7));
        write_reg(wcd_pkg::REG_FALL_THRESHOLD, thr_word(4'd2));
        queue_random_stamps(340, $urandom_range(0, 100000));
        repeat (200) @(posedge i_clk);
        hold_asked++;
        wait_drained();

        if (mismatches == 0 && debounce_results_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
